// File: hw/rtl/skhm_pkg.sv
`timescale 1ns / 1ps
package skhm_pkg;

  // Result status codes.
  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_ABSENT   = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_REPLACED = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // Operation codes.
  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  // FNV-1a 64 constants. The prime is 2^40 + 0x1b3, so a multiply by it is
  // a 40-bit shift plus a narrow product.
  localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
  localparam int unsigned FNV_SHIFT    = 40;
  localparam logic [63:0] FNV_PRIME_LO = 64'h00000000000001b3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       clr_wr;
    logic       load;
    logic       hash_step;
    logic       mod_step;
    logic       bkt_rd;
    logic       entry_rd;
    logic       insert;
    logic       replace;
    logic       advance;
    logic       res_set;
    logic [2:0] res_code;
    logic       out_load;
  } skhm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic hash_last;
    logic mod_last;
    logic is_set;
    logic occ;
    logic idx_ok;
    logic can_insert;
    logic key_eq;
    logic probe_last;
  } skhm_stat_t;

endpackage

// File: hw/rtl/skhm_ram.sv
`timescale 1ns / 1ps
module skhm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/skhm_dp.sv
`timescale 1ns / 1ps
module skhm_dp import skhm_pkg::*; #(
  parameter int unsigned BUCKETS       = 1024,
  parameter int unsigned ENTRIES       = 512,
  parameter int unsigned MAX_KEY_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  skhm_cmd_t   cmd_i,
  output skhm_stat_t  stat_o,
  input  logic        operation_i,
  input  logic [63:0] key_bytes_i,
  input  logic [31:0] set_value_i,
  output logic [2:0]  status_o,
  output logic [31:0] read_value_o
);

  localparam int unsigned BW   = $clog2(BUCKETS);
  localparam int unsigned IW   = $clog2(ENTRIES);
  localparam int unsigned CW   = $clog2(ENTRIES + 1);
  localparam bit          POW2 = (BUCKETS == (1 << BW));
  // Reciprocal of the bucket count, scaled by 2^(32 + BW).
  localparam logic [32:0] MOD_MUL = 33'((64'd1 << (32 + BW)) / 64'(BUCKETS));

  logic          op_q;
  logic [63:0]   key_q;
  logic [31:0]   val_q;
  logic [3:0]    len_q;
  logic [63:0]   hash_q, hash_d;
  logic [5:0]    cnt_q, cnt_d;
  logic [BW-1:0] slot_q, slot_d;
  logic [BW-1:0] probe_q, probe_d;
  logic [CW-1:0] count_q;
  logic [IW-1:0] idx_q;
  logic [2:0]    pend_status_q;
  logic [31:0]   pend_value_q;
  logic [2:0]    status_q;
  logic [31:0]   value_q;
  logic [31:0]   quot_q;

  logic [63:0]   key_c;
  logic [3:0]    len_c;
  logic          end_seen;
  logic [7:0]    cur_byte;
  logic [63:0]   mix;
  logic [15:0]   mod_digit;
  logic [31:0]   mod_t;
  logic [64:0]   mod_prod;
  logic [31:0]   quot_c;
  logic [31:0]   mod_r;
  logic [31:0]   mod_rem;

  logic [IW:0]   bkt_rdata;
  logic [IW:0]   bkt_wdata;
  logic          bkt_occ;
  logic [IW-1:0] bkt_idx;
  logic [63:0]   key_rdata;
  logic [31:0]   val_rdata;
  logic [IW-1:0] val_waddr;

  // Cut the key at its first zero byte and clear everything after it.
  always_comb begin
    key_c    = '0;
    len_c    = '0;
    end_seen = 1'b0;
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      if (!end_seen && (key_bytes_i[8*i +: 8] != 8'd0)) begin
        key_c[8*i +: 8] = key_bytes_i[8*i +: 8];
        len_c           = 4'(i + 1);
      end else begin
        end_seen = 1'b1;
      end
    end
  end

  // One FNV-1a round per cycle; bytes past the key length leave the hash alone.
  assign cur_byte = key_q[{cnt_q[2:0], 3'b000} +: 8];
  assign mix      = hash_q ^ {56'd0, cur_byte};

  always_comb begin
    hash_d = hash_q;
    if (cmd_i.load) begin
      hash_d = FNV_BASIS;
    end else if (cmd_i.hash_step && ({2'b00, cnt_q[3:0]} < {2'b00, len_q})) begin
      hash_d = (mix << FNV_SHIFT) + (mix * FNV_PRIME_LO);
    end
  end

  // Step counter shared by the hash rounds and the bucket reduction.
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      cnt_d = '0;
    end else if (cmd_i.hash_step) begin
      cnt_d = stat_o.hash_last ? 6'd0 : cnt_q + 6'd1;
    end else if (cmd_i.mod_step) begin
      cnt_d = cnt_q + 6'd1;
    end
  end

  // Bucket reduction for a BUCKETS that is not a power of two, one 16-bit hash digit
  // at a time, most significant first. An even step estimates the quotient by reciprocal
  // multiplication, an odd step subtracts it and corrects an estimate one too small.
  assign mod_digit = hash_q[{2'b11 - cnt_q[2:1], 4'b1111} -: 16];
  assign mod_t     = {16'(slot_q), mod_digit};
  assign mod_prod  = {33'd0, mod_t} * {32'd0, MOD_MUL};
  assign quot_c    = 32'(mod_prod >> (32 + BW));
  assign mod_r     = mod_t - (quot_q * 32'(BUCKETS));
  assign mod_rem   = (mod_r >= 32'(BUCKETS)) ? mod_r - 32'(BUCKETS) : mod_r;

  // Slot register: clear sweep address, remainder, then probe position.
  always_comb begin
    slot_d  = slot_q;
    probe_d = probe_q;
    if (cmd_i.clr_wr) begin
      slot_d = stat_o.clr_last ? '0 : slot_q + 1'b1;
    end else if (cmd_i.load) begin
      slot_d  = '0;
      probe_d = '0;
    end else if (cmd_i.mod_step) begin
      if (POW2) begin
        slot_d = hash_q[BW-1:0];
      end else if (cnt_q[0]) begin
        slot_d = mod_rem[BW-1:0];
      end
    end else if (cmd_i.advance) begin
      slot_d  = (slot_q == BW'(BUCKETS - 1)) ? '0 : slot_q + 1'b1;
      probe_d = probe_q + 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      probe_q <= '0;
      count_q <= '0;
      cnt_q   <= '0;
    end else begin
      slot_q  <= slot_d;
      probe_q <= probe_d;
      cnt_q   <= cnt_d;
      if (cmd_i.insert) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // Transaction and result payload registers.
  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    if (cmd_i.load) begin
      op_q  <= operation_i;
      key_q <= key_c;
      val_q <= set_value_i;
      len_q <= len_c;
    end
    if (cmd_i.mod_step && !cnt_q[0]) begin
      quot_q <= quot_c;
    end
    if (cmd_i.entry_rd) begin
      idx_q <= bkt_idx;
    end
    if (cmd_i.res_set) begin
      pend_status_q <= cmd_i.res_code;
      pend_value_q  <= (cmd_i.res_code == ST_FOUND) ? val_rdata : 32'd0;
    end
    if (cmd_i.out_load) begin
      status_q <= pend_status_q;
      value_q  <= pend_value_q;
    end
  end

  // Bucket store: occupied flag and entry index per bucket.
  assign bkt_wdata = cmd_i.insert ? {1'b1, count_q[IW-1:0]} : '0;
  assign bkt_occ   = bkt_rdata[IW];
  assign bkt_idx   = bkt_rdata[IW-1:0];

  skhm_ram #(.WIDTH(IW + 1), .DEPTH(BUCKETS)) u_bkt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_wr | cmd_i.insert),
    .waddr_i (slot_q),
    .wdata_i (bkt_wdata),
    .re_i    (cmd_i.bkt_rd),
    .raddr_i (slot_q),
    .rdata_o (bkt_rdata)
  );

  // Entry key store.
  skhm_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.insert),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (key_q),
    .re_i    (cmd_i.entry_rd),
    .raddr_i (bkt_idx),
    .rdata_o (key_rdata)
  );

  // Entry value store.
  assign val_waddr = cmd_i.insert ? count_q[IW-1:0] : idx_q;

  skhm_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.insert | cmd_i.replace),
    .waddr_i (val_waddr),
    .wdata_i (val_q),
    .re_i    (cmd_i.entry_rd),
    .raddr_i (bkt_idx),
    .rdata_o (val_rdata)
  );

  // Status toward the controller.
  assign stat_o.clr_last   = (slot_q == BW'(BUCKETS - 1));
  assign stat_o.hash_last  = (cnt_q == 6'(MAX_KEY_BYTES - 1));
  assign stat_o.mod_last   = POW2 || (cnt_q == 6'd7);
  assign stat_o.is_set     = (op_q == OP_SET);
  assign stat_o.occ        = bkt_occ;
  assign stat_o.idx_ok     = ({1'b0, bkt_idx} < (IW+1)'(ENTRIES));
  assign stat_o.can_insert = (count_q < CW'(ENTRIES));
  assign stat_o.key_eq     = (key_rdata == key_q);
  assign stat_o.probe_last = (probe_q == BW'(BUCKETS - 1));

  assign status_o     = status_q;
  assign read_value_o = value_q;

`ifndef SYNTH
  // A new entry only goes into an empty bucket while the store has room.
  a_insert_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |-> (!bkt_occ && stat_o.can_insert && stat_o.is_set))
    else $error("insert without room or into an occupied bucket");

  // A value is only overwritten after a key match on a set.
  a_replace_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.replace |-> (stat_o.key_eq && stat_o.is_set && !cmd_i.insert))
    else $error("replace without a matching key");

  // The entry count never passes the store size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ENTRIES))
    else $error("entry count overflow");
`endif

endmodule

// File: hw/rtl/skhm_ctrl.sv
`timescale 1ns / 1ps
module skhm_ctrl import skhm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  skhm_stat_t stat_i,
  output skhm_cmd_t  cmd_o
);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_HASH    = 3'd2;
  localparam logic [2:0] S_MOD     = 3'd3;
  localparam logic [2:0] S_BKT_RD  = 3'd4;
  localparam logic [2:0] S_BKT_CHK = 3'd5;
  localparam logic [2:0] S_KEY_CHK = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic [2:0] miss_code;

  assign miss_code  = stat_i.is_set ? ST_FULL : ST_ABSENT;
  assign in_stall_o = (state_q != S_IDLE);

  // Sequencer for the clear sweep, hashing, reduction and probing.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        cmd_o.hash_step = 1'b1;
        if (stat_i.hash_last) begin
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (stat_i.mod_last) begin
          state_d = S_BKT_RD;
        end
      end
      S_BKT_RD: begin
        cmd_o.bkt_rd = 1'b1;
        state_d      = S_BKT_CHK;
      end
      S_BKT_CHK: begin
        if (!stat_i.occ) begin
          // Empty bucket ends the probe: insert or report a miss.
          cmd_o.res_set = 1'b1;
          if (stat_i.is_set && stat_i.can_insert) begin
            cmd_o.insert   = 1'b1;
            cmd_o.res_code = ST_INSERTED;
          end else begin
            cmd_o.res_code = miss_code;
          end
          state_d = S_DONE;
        end else if (stat_i.idx_ok) begin
          cmd_o.entry_rd = 1'b1;
          state_d        = S_KEY_CHK;
        end else if (stat_i.probe_last) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = miss_code;
          state_d        = S_DONE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_BKT_RD;
        end
      end
      S_KEY_CHK: begin
        if (stat_i.key_eq) begin
          cmd_o.res_set = 1'b1;
          if (stat_i.is_set) begin
            cmd_o.replace  = 1'b1;
            cmd_o.res_code = ST_REPLACED;
          end else begin
            cmd_o.res_code = ST_FOUND;
          end
          state_d = S_DONE;
        end else if (stat_i.probe_last) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = miss_code;
          state_d        = S_DONE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_BKT_RD;
        end
      end
      S_DONE: begin
        // Move the result into the output register once it is free.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid holds until the result transaction completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // An accepted transaction always starts hashing in the next cycle.
  a_load_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_HASH))
    else $error("accepted transaction did not start hashing");

  // A result is never loaded over one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output overwritten while stalled");

  // A pending result is recorded before it is presented.
  a_res_before_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_set |=> (state_q == S_DONE))
    else $error("result recorded outside the finishing path");
`endif

endmodule

// File: hw/rtl/string_key_hash_map.sv
`timescale 1ns / 1ps
// A transaction runs through hashing over MAX_KEY_BYTES key bytes, bucket reduction,
// then a bucket read and check per probed bucket plus a key compare for each
// occupied bucket with a valid index, then a load into the output register.
// The block takes one transaction at a time and stalls input until the
// result has moved into the output register, which can wait on out_stall_i.
// Reset clears control state, then a sweep over every bucket empties the bucket
// store; input is stalled during that sweep.
module string_key_hash_map import skhm_pkg::*; #(
  parameter int unsigned BUCKETS       = 1024,
  parameter int unsigned ENTRIES       = 512,
  parameter int unsigned MAX_KEY_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [63:0] key_bytes_i,
  input  logic [31:0] set_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] read_value_o
);

  skhm_cmd_t  cmd;
  skhm_stat_t stat;

  // Controller.
  skhm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath with the hash unit and the three stores.
  skhm_dp #(
    .BUCKETS       (BUCKETS),
    .ENTRIES       (ENTRIES),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .operation_i  (operation_i),
    .key_bytes_i  (key_bytes_i),
    .set_value_i  (set_value_i),
    .status_o     (status_o),
    .read_value_o (read_value_o)
  );

endmodule

// File: tb/string_key_hash_map_tb.sv
`timescale 1ns / 1ps
module string_key_hash_map_tb;
  import skhm_pkg::*;

  localparam int unsigned BUCKETS  = 1024;
  localparam int unsigned ENTRIES  = 512;
  localparam int unsigned KEY_MAX  = 8;
  localparam logic [63:0] FNV_MULT = 64'h00000100000001b3;
  localparam int unsigned IDLE_LIMIT = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        operation_i;
  logic [63:0] key_bytes_i;
  logic [31:0] set_value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [31:0] read_value_o;

  string_key_hash_map dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .key_bytes_i  (key_bytes_i),
    .set_value_i  (set_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .read_value_o (read_value_o)
  );

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value;
  } map_result_t;

  // Shadow copy of the table.
  bit          shadow_occ [BUCKETS];
  int unsigned shadow_idx [BUCKETS];
  logic [63:0] shadow_key [ENTRIES];
  logic [31:0] shadow_val [ENTRIES];
  int unsigned shadow_count;

  // Keys written so far, for reuse in later transactions.
  logic [63:0] known_keys [$];
  map_result_t pending_results [$];

  int errors;
  int idle_cycles;
  int send_idle_pct;
  int stall_pct;
  bit hold_off;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Key with every byte after its first zero byte cleared.
  function automatic logic [63:0] trim_key(logic [63:0] raw, output int unsigned len);
    logic [63:0] k;
    k = '0;
    len = 0;
    for (int i = 0; i < KEY_MAX; i++) begin
      if (raw[8*i +: 8] == 8'h00) break;
      k[8*i +: 8] = raw[8*i +: 8];
      len = i + 1;
    end
    return k;
  endfunction

  function automatic logic [63:0] fnv_hash(logic [63:0] k, int unsigned len);
    logic [63:0] h;
    h = FNV_BASIS;
    for (int i = 0; i < len; i++) h = (h ^ {56'h0, k[8*i +: 8]}) * FNV_MULT;
    return h;
  endfunction

  // Apply one transaction to the shadow table and return its result.
  function automatic map_result_t lookup_update(logic op, logic [63:0] raw,
                                                 logic [31:0] val);
    map_result_t r;
    int unsigned len;
    int unsigned slot;
    logic [63:0] key;
    key = trim_key(raw, len);
    slot = 32'(fnv_hash(key, len) % BUCKETS);
    r.status = (op == OP_SET) ? ST_FULL : ST_ABSENT;
    r.value = '0;
    for (int n = 0; n < BUCKETS; n++) begin
      if (!shadow_occ[slot]) begin
        if (op == OP_SET && shadow_count < ENTRIES) begin
          shadow_key[shadow_count] = key;
          shadow_val[shadow_count] = val;
          shadow_idx[slot] = shadow_count;
          shadow_occ[slot] = 1'b1;
          shadow_count++;
          r.status = ST_INSERTED;
        end
        break;
      end
      if (shadow_idx[slot] < ENTRIES && shadow_key[shadow_idx[slot]] == key) begin
        if (op == OP_SET) begin
          shadow_val[shadow_idx[slot]] = val;
          r.status = ST_REPLACED;
        end else begin
          r.value = shadow_val[shadow_idx[slot]];
          r.status = ST_FOUND;
        end
        break;
      end
      slot = (slot + 1) % BUCKETS;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // Offer one transaction and wait until it is accepted. Valid stays high
  // after acceptance until the next idle cycle or the next drain.
  task automatic send_item(logic op, logic [63:0] raw, logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_bytes_i <= raw;
    set_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(lookup_update(op, raw, val));
    if (op == OP_SET) known_keys.push_back(raw);
  endtask

  // Stop offering and wait until every expected result has arrived.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Random raw key: mostly short keys so that reuse and collisions happen.
  function automatic logic [63:0] random_key();
    logic [63:0] k;
    int unsigned len;
    k = {$urandom, $urandom};
    len = $urandom_range(8);
    for (int i = 0; i < KEY_MAX; i++) begin
      if ($urandom_range(3) == 0) k[8*i +: 8] = 8'h00;
      else if (i < len && k[8*i +: 8] == 8'h00) k[8*i +: 8] = 8'h41;
    end
    if ($urandom_range(3) == 0) k[63:8] = {7{8'($urandom_range(1, 3))}};
    return k;
  endfunction

  // Reuse a stored key, sometimes with junk after its end.
  function automatic logic [63:0] reused_key();
    logic [63:0] k;
    int unsigned len;
    logic [63:0] junk;
    k = known_keys[$urandom_range(known_keys.size() - 1)];
    k = trim_key(k, len);
    junk = {$urandom, $urandom};
    if (len < KEY_MAX && $urandom_range(1)) k = k | ((junk << (8 * (len + 1))));
    return k;
  endfunction

  task automatic random_items(int count);
    logic [63:0] k;
    for (int i = 0; i < count; i++) begin
      if (known_keys.size() != 0 && $urandom_range(99) < 60) k = reused_key();
      else k = random_key();
      send_item(logic'($urandom_range(1)), k, $urandom);
    end
  endtask

  // Result checking.
  always @(posedge clk_i) begin
    map_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", {29'h0, status_o}, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", {29'h0, status_o}, {29'h0, want.status});
        if (read_value_o !== want.value)
          report_mismatch("read_value", read_value_o, want.value);
      end
    end
  end

  // Receiver stalls, with a long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog on cycles without any accepted transaction or delivered result.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[string_key_hash_map] ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(OP_GET, 64'h0, 32'h0);
    send_item(OP_SET, 64'h0, 32'hffffffff);
    send_item(OP_GET, 64'h0, 32'h0);
    send_item(OP_SET, 64'hffffffffffffffff, 32'h0);
    send_item(OP_GET, 64'hffffffffffffffff, 32'h1);
    send_item(OP_SET, 64'h00ff000000000061, 32'h12345678);
    send_item(OP_GET, 64'h0000000000000061, 32'h0);
    send_item(OP_SET, 64'h0000000000000061, 32'h87654321);
    send_item(OP_GET, 64'hffffffffff000061, 32'h0);
    send_item(OP_GET, 64'h8080808080808080, 32'h0);
    send_item(OP_SET, 64'h0102030405060708, 32'h55aa55aa);
    send_item(OP_GET, 64'h0102030405060708, 32'h0);
    send_item(OP_GET, 64'h0000000000000062, 32'h0);
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 0;  stall_pct = 0;  random_items(250);
    send_idle_pct = 59; stall_pct = 0;  random_items(200);
    send_idle_pct = 0;  stall_pct = 59; random_items(200);
    send_idle_pct = 26; stall_pct = 26; random_items(200);
  endtask

  // Receiver holds off while the sender keeps offering.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        random_items(40);
        // Sender pauses until everything is back.
        wait_drained();
      end
    join
    random_items(20);
  endtask

  // Fill the entry store so that new keys are rejected.
  task automatic test_full_store();
    int n;
    n = 0;
    send_idle_pct = 10;
    stall_pct = 10;
    while (shadow_count < ENTRIES) begin
      send_item(OP_SET, {32'h0, 8'h5a, 8'h01 + 8'(n % 200), 8'h01 + 8'(n / 200), 8'h4b},
                $urandom);
      n++;
    end
    send_item(OP_SET, 64'h0000000000777777, 32'h1);
    send_item(OP_GET, 64'h0000000000777777, 32'h0);
    random_items(300);
  endtask

  initial begin
    errors = 0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    shadow_count = 0;
    for (int i = 0; i < BUCKETS; i++) shadow_occ[i] = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = OP_GET;
    key_bytes_i = '0;
    set_value_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_idle_phases();
    test_backpressure();
    test_full_store();

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("[string_key_hash_map] OK");
    end else begin
      $display("[string_key_hash_map] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/skhm_pkg.sv
hw/rtl/skhm_ram.sv
hw/rtl/skhm_dp.sv
hw/rtl/skhm_ctrl.sv
hw/rtl/string_key_hash_map.sv
tb/string_key_hash_map_tb.sv
